// ===== rtl/akm_pkg.sv =====
// Shared constants, types and character helpers for the keyword matcher.
package akm_pkg;

    localparam int NUM_ENTRIES = 32;
    localparam int NAME_LEN    = 10;

    localparam int ENTRY_W = $clog2(NUM_ENTRIES);
    localparam int LANE_W  = $clog2(NAME_LEN);
    localparam int MATCH_W = $clog2(NAME_LEN + 1);
    localparam int REQ_W   = 2;
    localparam int IDX_W   = 5;
    localparam int POS_W   = 4;
    localparam int CHAR_W  = 8;
    localparam int CODE_W  = 8;
    localparam int LEN_W   = 4;
    localparam int CFG_W   = 6;
    localparam int CMP_W   = (ENTRY_W + 1 > CFG_W) ? ENTRY_W + 1 : CFG_W;

    typedef logic [CHAR_W-1:0] t_char;
    typedef t_char [NAME_LEN-1:0] t_row;

    localparam t_char NUL = '0;

    typedef enum logic [REQ_W-1:0] {
        REQ_TABLE = 2'd0,
        REQ_CHAR  = 2'd1,
        REQ_END   = 2'd2,
        REQ_RSVD  = 2'd3
    } t_req;

    typedef struct packed {
        logic eq;
        logic used;
    } t_link;

    typedef struct packed {
        logic eq;
        logic hit;
    } t_chain_res;

    function automatic t_char upcase(input t_char ch);
        if (ch >= 8'd97 && ch <= 8'd122) begin
            return ch - 8'd32;
        end
        return ch;
    endfunction

    function automatic logic is_blank(input t_char ch);
        return (ch == 8'd32) || (ch >= 8'd9 && ch <= 8'd13);
    endfunction

endpackage

// ===== rtl/abbreviated_keyword_matcher.sv =====
// Top level of the abbreviated keyword matcher.
//
//  channel  dir  handshake          payload
//  request  in   i_valid / o_ready  req_type, entry_index, char_pos, char_value, entry_code
//  result   out  o_valid / i_ready  token_code, match_length, char_pushed_back
//  config   in   i_cfg_we           i_cfg_data (entry_count)
//
// Table write, skipped blank or reserved request: taken in the idle state; end of
// input: accepted, then code read and result load.
// Stream character: accepted, then one table entry examined per cycle, one
// name row read from the name memory each cycle; a match end adds the code
// read and the result load.
// Reset clears the match state; the tables are not cleared and no sweep runs.
// A result waiting on i_ready holds only the step that loads the next result.
module abbreviated_keyword_matcher (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [akm_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [akm_pkg::REQ_W-1:0]     i_req_type,
    input  logic [akm_pkg::IDX_W-1:0]     i_entry_index,
    input  logic [akm_pkg::POS_W-1:0]     i_char_pos,
    input  logic [akm_pkg::CHAR_W-1:0]    i_char_value,
    input  logic [akm_pkg::CODE_W-1:0]    i_entry_code,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [akm_pkg::CODE_W-1:0]    o_token_code,
    output logic [akm_pkg::LEN_W-1:0]     o_match_length,
    output logic                          o_char_pushed_back
);
    import akm_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_CODE,
        S_EMIT
    } t_state;

    t_state               r_state, n_state;
    logic [CFG_W-1:0]     r_count;
    logic [ENTRY_W-1:0]   r_cur, n_cur;
    logic [ENTRY_W-1:0]   r_rd_entry, n_rd_entry;
    logic                 r_first, n_first;
    logic [MATCH_W-1:0]   r_matched, n_matched;
    logic                 r_skip, n_skip;
    t_char                r_want, n_want;
    logic                 r_push, n_push;
    logic                 r_o_valid, n_o_valid;
    logic [CODE_W-1:0]    r_o_code, n_o_code;
    logic [LEN_W-1:0]     r_o_len, n_o_len;
    logic                 r_o_push, n_o_push;

    t_row                 r_names [NUM_ENTRIES];
    t_row                 r_row;
    logic [CODE_W-1:0]    r_codes [NUM_ENTRIES];
    logic [CODE_W-1:0]    r_code_q;

    t_req                 req;
    logic                 accept;
    logic                 wr_en;
    logic [ENTRY_W-1:0]   rd_addr;
    logic [ENTRY_W-1:0]   next_entry;
    logic [CMP_W-1:0]     next_entry_x;
    logic [CMP_W-1:0]     count_x;
    logic [CMP_W-1:0]     active;
    logic                 ok;
    logic                 hit;
    logic                 consume;
    logic                 restart;
    t_chain_res           chain_res;

    assign o_ready            = (r_state == S_IDLE);
    assign accept             = i_valid && o_ready;
    assign req                = t_req'(i_req_type);
    assign o_valid            = r_o_valid;
    assign o_token_code       = r_o_code;
    assign o_match_length     = r_o_len;
    assign o_char_pushed_back = r_o_push;

    assign count_x      = CMP_W'(r_count);
    assign active       = (count_x > CMP_W'(NUM_ENTRIES)) ? CMP_W'(NUM_ENTRIES) : count_x;
    assign next_entry   = r_rd_entry + 1'b1;
    assign next_entry_x = CMP_W'(r_rd_entry) + CMP_W'(1);
    assign rd_addr      = (r_state == S_IDLE) ? r_cur : next_entry;
    assign ok           = r_first || chain_res.eq;
    assign hit          = chain_res.hit && (r_want != NUL);

    assign wr_en = accept && (req == REQ_TABLE)
                 && (32'(i_entry_index) < NUM_ENTRIES) && (32'(i_char_pos) < NAME_LEN);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_names[ENTRY_W'(i_entry_index)][LANE_W'(i_char_pos)] <= i_char_value;
        end else begin
            r_row <= r_names[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_codes[ENTRY_W'(i_entry_index)] <= i_entry_code;
        end
        r_code_q <= r_codes[r_cur];
    end

    akm_chain u_chain (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_row     (r_row),
        .i_want    (r_want),
        .i_consume (consume),
        .i_restart (restart),
        .o_res     (chain_res)
    );

    always_comb begin
        n_state    = r_state;
        n_cur      = r_cur;
        n_rd_entry = r_rd_entry;
        n_first    = r_first;
        n_matched  = r_matched;
        n_skip     = r_skip;
        n_want     = r_want;
        n_push     = r_push;
        n_o_valid  = r_o_valid;
        n_o_code   = r_o_code;
        n_o_len    = r_o_len;
        n_o_push   = r_o_push;
        consume    = 1'b0;
        restart    = 1'b0;

        if (i_ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (req)
                        REQ_CHAR: begin
                            if (!(r_skip && is_blank(i_char_value))) begin
                                n_skip = 1'b0;
                                n_want = upcase(i_char_value);
                                if (active == '0) begin
                                    n_push  = 1'b1;
                                    n_state = S_CODE;
                                end else begin
                                    n_first    = 1'b1;
                                    n_rd_entry = r_cur;
                                    n_state    = S_EVAL;
                                end
                            end
                        end
                        REQ_END: begin
                            n_push  = 1'b0;
                            n_state = S_CODE;
                        end
                        default: ;
                    endcase
                end
            end
            S_EVAL: begin
                if (!ok) begin
                    n_push  = 1'b1;
                    n_state = S_CODE;
                end else begin
                    n_cur = r_rd_entry;
                    if (hit) begin
                        consume   = 1'b1;
                        n_matched = r_matched + 1'b1;
                        n_state   = S_IDLE;
                    end else if (next_entry_x >= active) begin
                        n_push  = 1'b1;
                        n_state = S_CODE;
                    end else begin
                        n_rd_entry = next_entry;
                        n_first    = 1'b0;
                    end
                end
            end
            S_CODE: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_o_valid || i_ready) begin
                    n_o_valid = 1'b1;
                    n_o_code  = (active != '0 && r_matched != '0) ? r_code_q : '0;
                    n_o_len   = LEN_W'(r_matched);
                    n_o_push  = r_push;
                    restart   = 1'b1;
                    n_cur     = '0;
                    n_matched = '0;
                    n_skip    = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_cur     <= '0;
            r_matched <= '0;
            r_skip    <= 1'b1;
            r_first   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cur     <= n_cur;
            r_matched <= n_matched;
            r_skip    <= n_skip;
            r_first   <= n_first;
            r_o_valid <= n_o_valid;
            if (i_cfg_we) begin
                r_count <= i_cfg_data;
            end
        end
        r_rd_entry <= n_rd_entry;
        r_want     <= n_want;
        r_push     <= n_push;
        r_o_code   <= n_o_code;
        r_o_len    <= n_o_len;
        r_o_push   <= n_o_push;
    end

endmodule

// ===== rtl/akm_cell.sv =====
// One prefix cell: holds a consumed character and compares it with the fetched name.
module akm_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  akm_pkg::t_char i_row_char,
    input  akm_pkg::t_char i_want,
    input  logic           i_consume,
    input  logic           i_restart,
    input  akm_pkg::t_link i_link,
    output akm_pkg::t_link o_link,
    output logic           o_hit
);
    import akm_pkg::*;

    t_char r_char;
    logic  r_used;
    logic  tip;

    assign tip = i_link.used && !r_used;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
        end else if (i_restart) begin
            r_used <= 1'b0;
        end else if (i_consume && tip) begin
            r_used <= 1'b1;
        end
        if (i_consume && tip) begin
            r_char <= i_want;
        end
    end

    assign o_link.eq   = i_link.eq && (!r_used || (i_row_char == r_char));
    assign o_link.used = r_used;
    assign o_hit       = tip && (i_row_char == i_want);

endmodule

// ===== rtl/akm_chain.sv =====
// Row of prefix cells: prefix compare of a fetched name and hit at the next position.
module akm_chain (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  akm_pkg::t_row       i_row,
    input  akm_pkg::t_char      i_want,
    input  logic                i_consume,
    input  logic                i_restart,
    output akm_pkg::t_chain_res o_res
);
    import akm_pkg::*;

    t_link               links [NAME_LEN+1];
    logic [NAME_LEN-1:0] hits;

    assign links[0] = '{eq: 1'b1, used: 1'b1};

    for (genvar k = 0; k < NAME_LEN; k++) begin : g_cell
        akm_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_row_char (i_row[k]),
            .i_want     (i_want),
            .i_consume  (i_consume),
            .i_restart  (i_restart),
            .i_link     (links[k]),
            .o_link     (links[k+1]),
            .o_hit      (hits[k])
        );
    end

    assign o_res.eq  = links[NAME_LEN].eq;
    assign o_res.hit = |hits;

endmodule

// ===== rtl/akm_checker.sv =====
// Port-level checks for the keyword matcher, bound to the top level.
module akm_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       o_ready,
    input logic [akm_pkg::REQ_W-1:0]  i_req_type,
    input logic                       o_valid,
    input logic                       i_ready,
    input logic [akm_pkg::CODE_W-1:0] o_token_code,
    input logic [akm_pkg::LEN_W-1:0]  o_match_length,
    input logic                       o_char_pushed_back
);
    import akm_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_token_code)
            && $stable(o_match_length) && $stable(o_char_pushed_back))
        else $error("result word changed while stalled");

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> 32'(o_match_length) <= NAME_LEN)
        else $error("match length beyond name length");

    a_code_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_token_code != '0) |-> o_match_length != '0)
        else $error("token code without consumed characters");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("result or busy state after reset");

    a_end_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (i_req_type == REQ_END) |=> !o_ready)
        else $error("end of input did not start a result");

endmodule

bind abbreviated_keyword_matcher akm_checker u_akm_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_valid            (i_valid),
    .o_ready            (o_ready),
    .i_req_type         (i_req_type),
    .o_valid            (o_valid),
    .i_ready            (i_ready),
    .o_token_code       (o_token_code),
    .o_match_length     (o_match_length),
    .o_char_pushed_back (o_char_pushed_back)
);

// ===== bench/keyword_match_checker.sv =====
// Checker for the keyword matcher: tracks the table and match state, predicts tokens, compares.
module keyword_match_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [akm_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                       i_req_valid,
    input  logic                       i_req_ready,
    input  logic [akm_pkg::REQ_W-1:0]  i_req_type,
    input  logic [akm_pkg::IDX_W-1:0]  i_entry_index,
    input  logic [akm_pkg::POS_W-1:0]  i_char_pos,
    input  logic [akm_pkg::CHAR_W-1:0] i_char_value,
    input  logic [akm_pkg::CODE_W-1:0] i_entry_code,
    input  logic                       i_tok_valid,
    input  logic                       i_tok_ready,
    input  logic [akm_pkg::CODE_W-1:0] i_token_code,
    input  logic [akm_pkg::LEN_W-1:0]  i_match_length,
    input  logic                       i_char_pushed_back,
    output int                         o_fail_count,
    output int                         o_pending,
    output int                         o_checked
);
    import akm_pkg::*;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
        logic              pushed;
    } t_token;

    logic [CHAR_W-1:0] name_mem [NUM_ENTRIES][NAME_LEN];
    logic [CODE_W-1:0] code_mem [NUM_ENTRIES];
    logic [CFG_W-1:0]  entry_count;
    int                cur_entry;
    int                matched;
    bit                skip_blank;
    t_token            expected_tokens [$];
    int                fails = 0;
    int                checked = 0;

    task automatic report_mismatch(input string what, input int want, input int got);
        fails++;
        if (fails <= 50) begin
            $display("%0t  %s: expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    function automatic int live_entries();
        return (entry_count > NUM_ENTRIES) ? NUM_ENTRIES : int'(entry_count);
    endfunction

    function automatic int name_char(input int e, input int p);
        if (e >= NUM_ENTRIES || p >= NAME_LEN) begin
            return 0;
        end
        return int'(name_mem[e][p]);
    endfunction

    task automatic close_match(input bit pushed);
        t_token t;
        t.code   = (live_entries() != 0 && matched > 0) ? code_mem[cur_entry] : '0;
        t.len    = matched[LEN_W-1:0];
        t.pushed = pushed;
        expected_tokens.push_back(t);
        cur_entry  = 0;
        matched    = 0;
        skip_blank = 1'b1;
    endtask

    task automatic predict_word(
        input logic [REQ_W-1:0]  req,
        input logic [IDX_W-1:0]  idx,
        input logic [POS_W-1:0]  pos,
        input logic [CHAR_W-1:0] ch,
        input logic [CODE_W-1:0] code
    );
        int live;
        int want;
        int nxt;
        int c;
        case (req)
            REQ_TABLE: begin
                if (pos < NAME_LEN) begin
                    name_mem[idx][pos] = ch;
                    code_mem[idx]      = code;
                end
            end
            REQ_END: begin
                close_match(1'b0);
            end
            REQ_CHAR: begin
                if (skip_blank && (ch == 8'd32 || (ch >= 8'd9 && ch <= 8'd13))) begin
                    return;
                end
                skip_blank = 1'b0;
                live = live_entries();
                if (live == 0) begin
                    close_match(1'b1);
                    return;
                end
                want = (ch >= 8'd97 && ch <= 8'd122) ? int'(ch) - 32 : int'(ch);
                for (int walk = 0; walk <= NUM_ENTRIES; walk++) begin
                    if (want != 0 && matched < NAME_LEN
                            && name_char(cur_entry, matched) == want) begin
                        matched++;
                        return;
                    end
                    nxt = cur_entry + 1;
                    if (nxt >= live) begin
                        break;
                    end
                    for (c = 0; c < matched; c++) begin
                        if (name_char(nxt, c) == 0
                                || name_char(nxt, c) != name_char(cur_entry, c)) begin
                            break;
                        end
                    end
                    if (c != matched) begin
                        break;
                    end
                    cur_entry = nxt;
                end
                close_match(1'b1);
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_token got;
        t_token want;
        if (!i_rst_n) begin
            entry_count = '0;
            cur_entry   = 0;
            matched     = 0;
            skip_blank  = 1'b1;
            expected_tokens.delete();
        end else begin
            if (i_tok_valid && i_tok_ready) begin
                got.code   = i_token_code;
                got.len    = i_match_length;
                got.pushed = i_char_pushed_back;
                if (expected_tokens.size() == 0) begin
                    report_mismatch("token with nothing expected", -1, got.code);
                end else begin
                    want = expected_tokens.pop_front();
                    checked++;
                    if (got.code !== want.code) begin
                        report_mismatch("token_code", want.code, got.code);
                    end
                    if (got.len !== want.len) begin
                        report_mismatch("match_length", want.len, got.len);
                    end
                    if (got.pushed !== want.pushed) begin
                        report_mismatch("char_pushed_back", want.pushed, got.pushed);
                    end
                end
            end
            if (i_cfg_we) begin
                entry_count = i_cfg_data;
            end
            if (i_req_valid && i_req_ready) begin
                predict_word(i_req_type, i_entry_index, i_char_pos, i_char_value,
                             i_entry_code);
            end
        end
        o_pending    <= expected_tokens.size();
        o_fail_count <= fails;
        o_checked    <= checked;
    end

endmodule

// ===== bench/testbench.sv =====
// Top of the keyword matcher bench: clock, reset, stimulus, flow control and verdict.
module testbench;
    import akm_pkg::*;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [CFG_W-1:0]  i_cfg_data;
    logic              i_valid;
    logic              o_ready;
    logic [REQ_W-1:0]  i_req_type;
    logic [IDX_W-1:0]  i_entry_index;
    logic [POS_W-1:0]  i_char_pos;
    logic [CHAR_W-1:0] i_char_value;
    logic [CODE_W-1:0] i_entry_code;
    logic              o_valid;
    logic              i_ready;
    logic [CODE_W-1:0] o_token_code;
    logic [LEN_W-1:0]  o_match_length;
    logic              o_char_pushed_back;

    int fail_count;
    int pending;
    int checked;
    bit calm = 1'b0;
    bit hold_request = 1'b0;
    int words_sent = 0;
    int table_writes = 0;
    int settings_used = 0;
    int stall_left = 0;

    string kw_text [NUM_ENTRIES] = '{
        "ADDRESS", "ABORT", "CLEAR", "CLR", "CONFIG", "DISCONNECT", "ECHO", "EOI",
        "EOS", "HELLO", "HELP", "LISTEN", "LOCAL", "LOOP", "PARALLEL", "PPOLL",
        "QUERY", "QUIT", "READ", "READALL", "REMOTE", "RESET", "RESETALL", "SEND",
        "SERIAL", "SPOLL", "STATUS", "TALK", "TERMINATOR", "TIMEOUT", "TRIGGER", "WRITE"
    };

    int count_plan [10] = '{32, 63, 1, 17, 0, 32, 2, 40, 31, 32};

    abbreviated_keyword_matcher DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_req_type         (i_req_type),
        .i_entry_index      (i_entry_index),
        .i_char_pos         (i_char_pos),
        .i_char_value       (i_char_value),
        .i_entry_code       (i_entry_code),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_token_code       (o_token_code),
        .o_match_length     (o_match_length),
        .o_char_pushed_back (o_char_pushed_back)
    );

    keyword_match_checker u_check (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_data         (i_cfg_data),
        .i_req_valid        (i_valid),
        .i_req_ready        (o_ready),
        .i_req_type         (i_req_type),
        .i_entry_index      (i_entry_index),
        .i_char_pos         (i_char_pos),
        .i_char_value       (i_char_value),
        .i_entry_code       (i_entry_code),
        .i_tok_valid        (o_valid),
        .i_tok_ready        (i_ready),
        .i_token_code       (o_token_code),
        .i_match_length     (o_match_length),
        .i_char_pushed_back (o_char_pushed_back),
        .o_fail_count       (fail_count),
        .o_pending          (pending),
        .o_checked          (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("abbreviated_keyword_matcher: mismatch");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 30);
    endfunction

    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_ready = 1'b0;
                repeat (300) @(negedge i_clk);
            end else if (stall_left > 0) begin
                i_ready = 1'b0;
                stall_left--;
            end else begin
                i_ready = 1'b1;
                if (!calm && $urandom_range(0, 3) == 0) begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    task automatic send_word(input t_req req, input int idx, input int pos, input int ch,
                             input int code);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_req_type    = req;
        i_entry_index = IDX_W'(idx);
        i_char_pos    = POS_W'(pos);
        i_char_value  = CHAR_W'(ch);
        i_entry_code  = CODE_W'(code);
        i_valid       = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        if (req == REQ_TABLE) begin
            table_writes++;
        end else begin
            words_sent++;
        end
    endtask

    task automatic send_char(input int ch);
        send_word(REQ_CHAR, $urandom_range(0, 31), $urandom_range(0, 15), ch,
                  $urandom_range(0, 255));
    endtask

    task automatic send_end();
        send_word(REQ_END, $urandom_range(0, 31), $urandom_range(0, 15),
                  $urandom_range(0, 255), $urandom_range(0, 255));
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic set_entry_count(input int value);
        wait_drained();
        repeat (64) @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_data = CFG_W'(value);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        settings_used++;
    endtask

    task automatic send_phrase();
        string kw;
        int    n;
        int    cut;
        int    r;
        int    ch;
        n = $urandom_range(0, 2);
        repeat (n) begin
            r = $urandom_range(9, 14);
            send_char((r == 14) ? 32 : r);
        end
        kw  = kw_text[$urandom_range(0, NUM_ENTRIES - 1)];
        cut = $urandom_range(1, kw.len());
        for (int i = 0; i < cut; i++) begin
            ch = kw[i];
            if (ch >= "A" && ch <= "Z" && $urandom_range(0, 1) == 1) begin
                ch += 32;
            end
            send_char(ch);
        end
        r = $urandom_range(0, 99);
        if (r < 40) begin
            send_end();
        end else if (r < 65) begin
            send_char(32);
        end else if (r < 80) begin
            send_char($urandom_range(0, 255));
        end else if (r < 90) begin
            send_char(0);
        end else if (r < 95) begin
            send_char(kw_text[$urandom_range(0, NUM_ENTRIES - 1)][0]);
        end
    endtask

    task automatic send_noise();
        int r;
        int ch;
        r = $urandom_range(0, 99);
        if (r < 30) begin
            case ($urandom_range(0, 2))
                0:       ch = $urandom_range(65, 90);
                1:       ch = 0;
                default: ch = $urandom_range(0, 255);
            endcase
            send_word(REQ_TABLE, $urandom_range(0, 31), $urandom_range(0, 15), ch,
                      $urandom_range(0, 255));
        end else if (r < 70) begin
            send_char($urandom_range(0, 255));
        end else if (r < 90) begin
            send_end();
        end else begin
            send_word(REQ_RSVD, $urandom_range(0, 31), $urandom_range(0, 15),
                      $urandom_range(0, 255), $urandom_range(0, 255));
        end
    endtask

    initial begin
        string kw;
        int    code;
        int    mark;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_data    = '0;
        i_valid       = 1'b0;
        i_req_type    = REQ_TABLE;
        i_entry_index = '0;
        i_char_pos    = '0;
        i_char_value  = '0;
        i_entry_code  = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int e = 0; e < NUM_ENTRIES; e++) begin
            kw   = kw_text[e];
            code = (e == 0) ? 255 : $urandom_range(1, 254);
            for (int p = 0; p < NAME_LEN; p++) begin
                send_word(REQ_TABLE, e, p, (p < kw.len()) ? int'(kw[p]) : 0, code);
            end
        end

        send_char("A");
        send_char(9);
        send_char("b");
        send_end();
        send_word(REQ_RSVD, 0, 0, 0, 0);
        send_word(REQ_TABLE, 3, NAME_LEN, "Z", 8'hAA);
        send_word(REQ_TABLE, 31, 15, 8'hFF, 8'hFF);

        set_entry_count(NUM_ENTRIES);
        send_char(32);
        send_char(13);
        send_char("r");
        send_char("E");
        send_char("s");
        send_char(32);
        kw = "TERMINATOR";
        for (int i = 0; i < kw.len(); i++) begin
            send_char(kw[i]);
        end
        send_char("S");
        send_char(0);
        send_char(255);
        send_end();

        foreach (count_plan[ph]) begin
            set_entry_count(count_plan[ph]);
            calm = (ph == 3);
            if (ph == 4) begin
                hold_request = 1'b1;
            end
            mark = words_sent;
            while (words_sent - mark < 50) begin
                if (ph == 6 && words_sent - mark == 25) begin
                    wait_drained();
                end
                if ($urandom_range(0, 99) < 80) begin
                    send_phrase();
                end else begin
                    send_noise();
                end
            end
            send_char(kw_text[$urandom_range(0, NUM_ENTRIES - 1)][0]);
        end
        calm = 1'b0;

        wait_drained();
        repeat (64) @(negedge i_clk);
        $display("sent %0d stream and end words and %0d table writes over %0d entry_count settings",
                 words_sent, table_writes, settings_used);
        $display("compared %0d tokens, with a long receiver hold-off and drain pauses",
                 checked);
        if (fail_count == 0 && pending == 0) begin
            $display("abbreviated_keyword_matcher: match");
        end else begin
            $display("abbreviated_keyword_matcher: mismatch");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/akm_pkg.sv
rtl/akm_cell.sv
rtl/akm_chain.sv
rtl/abbreviated_keyword_matcher.sv
rtl/akm_checker.sv
bench/keyword_match_checker.sv
bench/testbench.sv
